// ===== rtl/core/hls_to_rgb_converter_core_defines.svh =====
// Assertion macros shared by the HLS to RGB converter core.
`ifndef HLS_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define HLS_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`ifndef SYNTH
`define HRC_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HRC_ASSERT(lbl, prop, msg) \
  `HRC_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)
`else
`define HRC_ASSERT_AT(lbl, clk, rstn, prop, msg)
`define HRC_ASSERT(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/hrc_pkg.sv =====
// Package with constants, types and constant dividers of the HLS to RGB converter.
`timescale 1ns / 1ps
package hrc_pkg;

  localparam int unsigned HLS_SCALE      = 240;
  localparam int unsigned RGB_TOP        = 255;
  localparam int unsigned HLS_SIXTH      = ((HLS_SCALE / 6) > 0) ? (HLS_SCALE / 6) : 1;
  localparam int unsigned HLS_TWELFTH    = HLS_SCALE / 12;
  localparam int unsigned HLS_THIRD      = HLS_SCALE / 3;
  localparam int unsigned HLS_TWO_THIRDS = (HLS_SCALE * 2) / 3;
  localparam int unsigned HLS_HALF       = HLS_SCALE / 2;

  localparam int unsigned CH_W  = 8;
  localparam int unsigned LVL_W = 8;
  localparam int unsigned QUO_W = LVL_W + 1;
  localparam int unsigned WGT_W = $clog2(HLS_SIXTH + 1);

  // Division by the scale: exact floor by reciprocal for any dividend below 2**DIV_IN_W.
  localparam int unsigned DIV_IN_W    = 17;
  localparam int unsigned HLS_SHIFT   = DIV_IN_W + $clog2(HLS_SCALE);
  localparam longint unsigned HLS_RECIP =
    ((64'd1 << HLS_SHIFT) + HLS_SCALE - 1) / HLS_SCALE;
  localparam int unsigned HLS_RECIP_W = $clog2(HLS_RECIP + 1);
  localparam int unsigned HLS_PROD_W  = DIV_IN_W + HLS_RECIP_W;

  // Division by one sixth of the scale, same scheme on the ramp numerator.
  localparam int unsigned RAMP_IN_W     = 14;
  localparam int unsigned SIXTH_SHIFT   = RAMP_IN_W + $clog2(HLS_SIXTH);
  localparam longint unsigned SIXTH_RECIP =
    ((64'd1 << SIXTH_SHIFT) + HLS_SIXTH - 1) / HLS_SIXTH;
  localparam int unsigned SIXTH_RECIP_W = $clog2(SIXTH_RECIP + 1);
  localparam int unsigned SIXTH_PROD_W  = RAMP_IN_W + SIXTH_RECIP_W;

  localparam int unsigned NUM_CH = 3;
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;

  typedef logic [CH_W-1:0]      ch_t;
  typedef logic [LVL_W-1:0]     lvl_t;
  typedef logic [QUO_W-1:0]     quo_t;
  typedef logic [DIV_IN_W-1:0]  div_in_t;
  typedef logic [RAMP_IN_W-1:0] ramp_in_t;

  typedef enum logic [1:0] {
    SEG_RAMP,
    SEG_HIGH,
    SEG_LOW
  } seg_e;

  typedef struct packed {
    lvl_t              light;
    lvl_t              sat;
    logic              zero;
    logic              light_hi;
    quo_t              quo;
    ch_t               grey;
    lvl_t [NUM_CH-1:0] hue;
  } front_t;

  typedef struct packed {
    lvl_t              m1;
    lvl_t              diff;
    lvl_t [NUM_CH-1:0] hue;
    ch_t               grey;
    logic              zero;
  } magic_t;

  function automatic quo_t div_scale(input div_in_t num);
    logic [HLS_PROD_W-1:0] prod;
    prod = HLS_PROD_W'(num) * HLS_PROD_W'(HLS_RECIP);
    return QUO_W'(prod >> HLS_SHIFT);
  endfunction

  function automatic lvl_t div_sixth(input ramp_in_t num);
    logic [SIXTH_PROD_W-1:0] prod;
    prod = SIXTH_PROD_W'(num) * SIXTH_PROD_W'(SIXTH_RECIP);
    return LVL_W'(prod >> SIXTH_SHIFT);
  endfunction

endpackage

// ===== rtl/core/hrc_if.sv =====
// Valid/ready channel interfaces for HLS input and RGB output transfers.
`timescale 1ns / 1ps
interface hrc_hls_if;
  import hrc_pkg::*;

  logic valid;
  logic ready;
  ch_t  hue_in;
  ch_t  lightness;
  ch_t  saturation;

  modport source (output valid, hue_in, lightness, saturation, input ready);
  modport sink (input valid, hue_in, lightness, saturation, output ready);
endinterface

interface hrc_rgb_if;
  import hrc_pkg::*;

  logic valid;
  logic ready;
  ch_t  red;
  ch_t  green;
  ch_t  blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

// ===== rtl/core/hls_to_rgb_converter_core.sv =====
// Top level of the HLS to RGB converter: six-stage pipeline with valid/ready channels.
//
//   Channel  Dir  Payload                        Handshake
//   hls_i    in   hue_in, lightness, saturation  valid / ready
//   rgb_o    out  red, green, blue               valid / ready
//
// One transfer per cycle in each direction while the output is not stalled.
// Depth is set by the two reciprocal dividers by the scale and the one by a sixth of it.
// Reset clears only the stage valid bits; the data registers are not reset.
// When a result waits and rgb_o.ready is low, all stages hold and hls_i.ready drops.
`timescale 1ns / 1ps
`include "hls_to_rgb_converter_core_defines.svh"
module hls_to_rgb_converter_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  hrc_hls_if.sink   hls_i,
  hrc_rgb_if.source rgb_o
);
  import hrc_pkg::*;

  localparam int unsigned DEPTH = 6;

  logic               en;
  logic [DEPTH-1:0]   vld_q;
  front_t             front;
  magic_t             magic;
  ch_t [NUM_CH-1:0]   rgb;
  ch_t                grey_s4_q;
  ch_t                grey_s5_q;
  logic               zero_s4_q;
  logic               zero_s5_q;
  ch_t [NUM_CH-1:0]   out_q;
  logic               grey_out_q;

  assign en          = !vld_q[DEPTH-1] || rgb_o.ready;
  assign hls_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], hls_i.valid};
    end
  end

  hrc_front u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .hue_i   (hls_i.hue_in),
    .light_i (hls_i.lightness),
    .sat_i   (hls_i.saturation),
    .front_o (front)
  );

  hrc_magic u_magic (
    .clk_i   (clk_i),
    .en_i    (en),
    .front_i (front),
    .magic_o (magic)
  );

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    hrc_channel u_channel (
      .clk_i  (clk_i),
      .en_i   (en),
      .m1_i   (magic.m1),
      .diff_i (magic.diff),
      .hue_i  (magic.hue[c]),
      .rgb_o  (rgb[c])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      grey_s4_q  <= magic.grey;
      zero_s4_q  <= magic.zero;
      grey_s5_q  <= grey_s4_q;
      zero_s5_q  <= zero_s4_q;
      grey_out_q <= zero_s5_q;
      for (int c = 0; c < NUM_CH; c++) begin
        out_q[c] <= zero_s5_q ? grey_s5_q : rgb[c];
      end
    end
  end

  assign rgb_o.valid = vld_q[DEPTH-1];
  assign rgb_o.red   = out_q[CH_RED];
  assign rgb_o.green = out_q[CH_GREEN];
  assign rgb_o.blue  = out_q[CH_BLUE];

  `HRC_ASSERT(a_accept_enters, hls_i.valid && hls_i.ready |=> vld_q[0], "Accepted transfer did not enter the first stage.")
  `HRC_ASSERT(a_stall_holds, !en |=> $stable(vld_q), "Stage valid bits moved during a stall.")
  `HRC_ASSERT(a_drain_empties, rgb_o.valid && rgb_o.ready && !vld_q[DEPTH-2] |=> !rgb_o.valid, "Output stayed valid after its transfer with no item behind it.")
  `HRC_ASSERT(a_grey_equal, rgb_o.valid && grey_out_q |-> (rgb_o.red == rgb_o.green) && (rgb_o.green == rgb_o.blue), "Grey result has unequal channels.")

endmodule

// ===== rtl/core/hrc_front.sv =====
// Input clamp, hue offsets, magic level numerator and scale division (two stages).
`timescale 1ns / 1ps
module hrc_front (
  input  logic            clk_i,
  input  logic            en_i,
  input  hrc_pkg::ch_t    hue_i,
  input  hrc_pkg::ch_t    light_i,
  input  hrc_pkg::ch_t    sat_i,
  output hrc_pkg::front_t front_o
);
  import hrc_pkg::*;

  lvl_t              h_c;
  lvl_t              l_c;
  lvl_t              s_c;
  logic [LVL_W:0]    h_up;
  logic [LVL_W:0]    h_dn;
  logic [LVL_W:0]    fac;
  logic              light_hi;
  lvl_t [NUM_CH-1:0] hue_d;
  div_in_t           num_d;
  div_in_t           grey_num_d;

  lvl_t              light_q;
  lvl_t              sat_q;
  logic              zero_q;
  logic              light_hi_q;
  lvl_t [NUM_CH-1:0] hue_q;
  div_in_t           num_q;
  div_in_t           grey_num_q;
  front_t            front_d;
  front_t            front_q;

  always_comb begin
    h_c = (hue_i > CH_W'(HLS_SCALE)) ? LVL_W'(HLS_SCALE) : LVL_W'(hue_i);
    l_c = (light_i > CH_W'(HLS_SCALE)) ? LVL_W'(HLS_SCALE) : LVL_W'(light_i);
    s_c = (sat_i > CH_W'(HLS_SCALE)) ? LVL_W'(HLS_SCALE) : LVL_W'(sat_i);

    h_up = {1'b0, h_c} + (LVL_W+1)'(HLS_THIRD);
    h_dn = {1'b0, h_c} + (LVL_W+1)'(HLS_SCALE - HLS_THIRD);
    hue_d[CH_RED]   = (h_up > (LVL_W+1)'(HLS_SCALE)) ?
                      LVL_W'(h_up - (LVL_W+1)'(HLS_SCALE)) : h_up[LVL_W-1:0];
    hue_d[CH_GREEN] = h_c;
    hue_d[CH_BLUE]  = (h_c < LVL_W'(HLS_THIRD)) ?
                      h_dn[LVL_W-1:0] : LVL_W'(h_c - LVL_W'(HLS_THIRD));

    light_hi   = (l_c > LVL_W'(HLS_HALF));
    fac        = light_hi ? {1'b0, s_c} : ({1'b0, s_c} + (LVL_W+1)'(HLS_SCALE));
    num_d      = DIV_IN_W'(l_c) * DIV_IN_W'(fac) + DIV_IN_W'(HLS_HALF);
    grey_num_d = DIV_IN_W'(l_c) * DIV_IN_W'(RGB_TOP);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      light_q    <= l_c;
      sat_q      <= s_c;
      zero_q     <= (s_c == '0);
      light_hi_q <= light_hi;
      hue_q      <= hue_d;
      num_q      <= num_d;
      grey_num_q <= grey_num_d;
    end
  end

  always_comb begin
    front_d.light    = light_q;
    front_d.sat      = sat_q;
    front_d.zero     = zero_q;
    front_d.light_hi = light_hi_q;
    front_d.quo      = div_scale(num_q);
    front_d.grey     = CH_W'(div_scale(grey_num_q));
    front_d.hue      = hue_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

// ===== rtl/core/hrc_magic.sv =====
// Stage that forms the low magic level and the level span.
`timescale 1ns / 1ps
module hrc_magic (
  input  logic            clk_i,
  input  logic            en_i,
  input  hrc_pkg::front_t front_i,
  output hrc_pkg::magic_t magic_o
);
  import hrc_pkg::*;

  logic [LVL_W+1:0] m2_w;
  lvl_t             m2;
  lvl_t             m1;
  magic_t           magic_q;

  always_comb begin
    m2_w = front_i.light_hi ?
           ({2'b00, front_i.light} + {2'b00, front_i.sat} - (LVL_W+2)'(front_i.quo)) :
           (LVL_W+2)'(front_i.quo);
    m2   = m2_w[LVL_W-1:0];
    m1   = LVL_W'({front_i.light, 1'b0} - {1'b0, m2});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      magic_q.m1   <= m1;
      magic_q.diff <= m2 - m1;
      magic_q.hue  <= front_i.hue;
      magic_q.grey <= front_i.grey;
      magic_q.zero <= front_i.zero;
    end
  end

  assign magic_o = magic_q;

endmodule

// ===== rtl/core/hrc_channel.sv =====
// Per-channel hue interpolation and conversion of the level to 8 bits.
`timescale 1ns / 1ps
module hrc_channel (
  input  logic          clk_i,
  input  logic          en_i,
  input  hrc_pkg::lvl_t m1_i,
  input  hrc_pkg::lvl_t diff_i,
  input  hrc_pkg::lvl_t hue_i,
  output hrc_pkg::ch_t  rgb_o
);
  import hrc_pkg::*;

  seg_e             seg_d;
  logic [WGT_W-1:0] wgt;
  seg_e             seg_q;
  lvl_t             m1_q;
  lvl_t             diff_q;
  ramp_in_t         ramp_q;
  lvl_t             level_d;
  lvl_t             level_q;

  always_comb begin
    if (hue_i < LVL_W'(HLS_SIXTH)) begin
      seg_d = SEG_RAMP;
      wgt   = WGT_W'(hue_i);
    end else if (hue_i < LVL_W'(HLS_HALF)) begin
      seg_d = SEG_HIGH;
      wgt   = '0;
    end else if (hue_i < LVL_W'(HLS_TWO_THIRDS)) begin
      seg_d = SEG_RAMP;
      wgt   = WGT_W'(LVL_W'(HLS_TWO_THIRDS) - hue_i);
    end else begin
      seg_d = SEG_LOW;
      wgt   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg_q  <= seg_d;
      m1_q   <= m1_i;
      diff_q <= diff_i;
      ramp_q <= RAMP_IN_W'(diff_i) * RAMP_IN_W'(wgt) + RAMP_IN_W'(HLS_TWELFTH);
    end
  end

  always_comb begin
    case (seg_q)
      SEG_RAMP: level_d = m1_q + div_sixth(ramp_q);
      SEG_HIGH: level_d = m1_q + diff_q;
      default:  level_d = m1_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      level_q <= level_d;
    end
  end

  assign rgb_o = CH_W'(div_scale(DIV_IN_W'(level_q) * DIV_IN_W'(RGB_TOP) +
                                 DIV_IN_W'(HLS_HALF)));

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the HLS to RGB converter core with directed and random pixels.
`timescale 1ns / 1ps
module tb;
  import hrc_pkg::*;

  localparam int SCALE      = int'(HLS_SCALE);
  localparam int SIXTH      = int'(HLS_SIXTH);
  localparam int TWELFTH    = int'(HLS_TWELFTH);
  localparam int THIRD      = int'(HLS_THIRD);
  localparam int TWO_THIRDS = int'(HLS_TWO_THIRDS);
  localparam int HALF       = int'(HLS_HALF);
  localparam int RGB_MAX    = int'(RGB_TOP);

  localparam int RANDOM_PIXELS = 1330;
  localparam int MAX_GAP       = 17;
  localparam int HOLD_CYCLES   = 64;
  localparam int HOLD_AT       = 250;
  localparam int DRAIN_CYCLES  = 12;
  localparam int IDLE_LIMIT    = 4000;
  localparam int PRINT_CAP     = 40;
  localparam int NUM_CASES     = 23;

  typedef struct packed {
    ch_t red;
    ch_t green;
    ch_t blue;
  } rgb_pixel_t;

  typedef struct packed {
    ch_t  hue;
    ch_t  light;
    ch_t  sat;
    logic known;
    ch_t  red;
    ch_t  green;
    ch_t  blue;
  } pixel_case_t;

  logic clk_i;
  logic rst_ni;

  hrc_hls_if hls_ch ();
  hrc_rgb_if rgb_ch ();

  hls_to_rgb_converter_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .hls_i (hls_ch),
    .rgb_o (rgb_ch)
  );

  rgb_pixel_t pending_rgb_q[$];
  int         mismatch_count = 0;
  int         pixels_sent    = 0;
  int         pixels_checked = 0;
  int         grey_count     = 0;
  int         clamped_count  = 0;
  bit         out_hold       = 1'b0;
  bit         hold_done      = 1'b0;
  bit         tx_calm        = 1'b0;

  // Hue boundaries, grey, clamped fields and both hue wraps.
  pixel_case_t directed_cases [NUM_CASES] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
    '{8'd0,   8'd240, 8'd0,   1'b1, 8'd255, 8'd255, 8'd255},
    '{8'd200, 8'd120, 8'd0,   1'b1, 8'd127, 8'd127, 8'd127},
    '{8'd255, 8'd255, 8'd0,   1'b1, 8'd255, 8'd255, 8'd255},
    '{8'd0,   8'd120, 8'd240, 1'b1, 8'd255, 8'd0,   8'd0},
    '{8'd80,  8'd120, 8'd240, 1'b1, 8'd0,   8'd255, 8'd0},
    '{8'd160, 8'd120, 8'd240, 1'b1, 8'd0,   8'd0,   8'd255},
    '{8'd240, 8'd120, 8'd240, 1'b1, 8'd255, 8'd0,   8'd0},
    '{8'd255, 8'd120, 8'd240, 1'b1, 8'd255, 8'd0,   8'd0},
    '{8'd0,   8'd240, 8'd240, 1'b1, 8'd255, 8'd255, 8'd255},
    '{8'd0,   8'd0,   8'd240, 1'b1, 8'd0,   8'd0,   8'd0},
    '{8'd0,   8'd120, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
    '{8'd0,   8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
    '{8'd40,  8'd120, 8'd240, 1'b0, 8'd0,   8'd0,   8'd0},
    '{8'd39,  8'd120, 8'd240, 1'b0, 8'd0,   8'd0,   8'd0},
    '{8'd119, 8'd120, 8'd240, 1'b0, 8'd0,   8'd0,   8'd0},
    '{8'd120, 8'd120, 8'd240, 1'b0, 8'd0,   8'd0,   8'd0},
    '{8'd159, 8'd120, 8'd240, 1'b0, 8'd0,   8'd0,   8'd0},
    '{8'd200, 8'd121, 8'd240, 1'b0, 8'd0,   8'd0,   8'd0},
    '{8'd30,  8'd60,  8'd1,   1'b0, 8'd0,   8'd0,   8'd0},
    '{8'd100, 8'd200, 8'd128, 1'b0, 8'd0,   8'd0,   8'd0},
    '{8'd20,  8'd90,  8'd170, 1'b0, 8'd0,   8'd0,   8'd0},
    '{8'd239, 8'd130, 8'd200, 1'b0, 8'd0,   8'd0,   8'd0}
  };

  function automatic int clamp_field(ch_t v);
    return (v > SCALE) ? SCALE : int'(v);
  endfunction

  function automatic int hue_level(int lo, int hi, int h);
    if (h < 0) h += SCALE;
    if (h > SCALE) h -= SCALE;
    if (h < SIXTH) return lo + ((hi - lo) * h + TWELFTH) / SIXTH;
    if (h < HALF) return hi;
    if (h < TWO_THIRDS) return lo + ((hi - lo) * (TWO_THIRDS - h) + TWELFTH) / SIXTH;
    return lo;
  endfunction

  function automatic ch_t level_to_byte(int level);
    int v;
    v = (level * RGB_MAX + HALF) / SCALE;
    if (v < 0) v = 0;
    if (v > RGB_MAX) v = RGB_MAX;
    return ch_t'(v);
  endfunction

  function automatic rgb_pixel_t convert_hls_pixel(ch_t hue, ch_t light, ch_t sat);
    rgb_pixel_t px;
    int h;
    int l;
    int s;
    int m1;
    int m2;
    h = clamp_field(hue);
    l = clamp_field(light);
    s = clamp_field(sat);
    if (s == 0) begin
      px.red   = ch_t'((l * RGB_MAX) / SCALE);
      px.green = px.red;
      px.blue  = px.red;
      return px;
    end
    if (l <= HALF) begin
      m2 = (l * (SCALE + s) + HALF) / SCALE;
    end else begin
      m2 = l + s - (l * s + HALF) / SCALE;
    end
    m1 = 2 * l - m2;
    px.red   = level_to_byte(hue_level(m1, m2, h + THIRD));
    px.green = level_to_byte(hue_level(m1, m2, h));
    px.blue  = level_to_byte(hue_level(m1, m2, h - THIRD));
    return px;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Called just after a falling edge; returns just after a falling edge once the pixel is accepted.
  task automatic send_pixel(ch_t hue, ch_t light, ch_t sat, rgb_pixel_t want);
    int gap;
    gap = (tx_calm || out_hold) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      hls_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    hls_ch.valid      <= 1'b1;
    hls_ch.hue_in     <= hue;
    hls_ch.lightness  <= light;
    hls_ch.saturation <= sat;
    do @(posedge clk_i); while (!hls_ch.ready);
    pending_rgb_q.push_back(want);
    pixels_sent++;
    if (sat == 8'd0) grey_count++;
    if (hue > SCALE || light > SCALE || sat > SCALE) clamped_count++;
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Output side: random stalls, calm stretches and one long hold-off.
  initial begin
    int stall;
    rgb_pixel_t want;
    rgb_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!hold_done && pixels_checked == HOLD_AT) begin
        hold_done = 1'b1;
        out_hold  = 1'b1;
        rgb_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_hold  = 1'b0;
      end else begin
        stall = ((pixels_checked / 80) % 2 == 1) ? 0 : $urandom_range(0, MAX_GAP);
        if (stall > 0) begin
          rgb_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      rgb_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rgb_ch.valid);
      if (pending_rgb_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer %0h %0h %0h",
                                  rgb_ch.red, rgb_ch.green, rgb_ch.blue));
      end else begin
        want = pending_rgb_q.pop_front();
        if (rgb_ch.red !== want.red)
          report_mismatch($sformatf("pixel %0d red %0d, predicted %0d",
                                    pixels_checked, rgb_ch.red, want.red));
        if (rgb_ch.green !== want.green)
          report_mismatch($sformatf("pixel %0d green %0d, predicted %0d",
                                    pixels_checked, rgb_ch.green, want.green));
        if (rgb_ch.blue !== want.blue)
          report_mismatch($sformatf("pixel %0d blue %0d, predicted %0d",
                                    pixels_checked, rgb_ch.blue, want.blue));
      end
      pixels_checked++;
      @(negedge clk_i);
    end
  end

  // The run ends here if no transfer happens on either side for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((hls_ch.valid && hls_ch.ready) || (rgb_ch.valid && rgb_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("timeout after %0d idle cycles", IDLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    pixel_case_t row;
    rgb_pixel_t  want;
    ch_t         hue;
    ch_t         light;
    ch_t         sat;
    rst_ni            = 1'b0;
    hls_ch.valid      = 1'b0;
    hls_ch.hue_in     = '0;
    hls_ch.lightness  = '0;
    hls_ch.saturation = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NUM_CASES; i++) begin
      row = directed_cases[i];
      if (row.known) begin
        want = '{red: row.red, green: row.green, blue: row.blue};
      end else begin
        want = convert_hls_pixel(row.hue, row.light, row.sat);
      end
      send_pixel(row.hue, row.light, row.sat, want);
    end

    // Mostly in-range fields, some above range, and a share of grey pixels.
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      tx_calm = ((i / 64) % 3 == 2);
      hue   = ($urandom_range(0, 7) == 0) ? ch_t'($urandom_range(0, 255))
                                          : ch_t'($urandom_range(0, SCALE));
      light = ($urandom_range(0, 7) == 0) ? ch_t'($urandom_range(0, 255))
                                          : ch_t'($urandom_range(0, SCALE));
      case ($urandom_range(0, 9))
        0: sat = 8'd0;
        1: sat = ch_t'($urandom_range(0, 255));
        default: sat = ch_t'($urandom_range(1, SCALE));
      endcase
      send_pixel(hue, light, sat, convert_hls_pixel(hue, light, sat));
    end
    hls_ch.valid <= 1'b0;

    while (pending_rgb_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d pixels (%0d directed), checked %0d results", pixels_sent, NUM_CASES,
             pixels_checked);
    $display("grey pixels %0d, pixels with a field above range %0d, long output hold %0d",
             grey_count, clamped_count, hold_done);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
